// ===== rtl/sha1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 byte-stream engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  byte_pos_t;
  typedef logic [6:0]  round_t;
  typedef logic [2:0]  word_idx_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } abcde_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam word_t K_0 = 32'h5A82_7999;
  localparam word_t K_1 = 32'h6ED9_EBA1;
  localparam word_t K_2 = 32'h8F1B_BCDC;
  localparam word_t K_3 = 32'hCA62_C1D6;

  localparam word_t H_INIT_0 = 32'h6745_2301;
  localparam word_t H_INIT_1 = 32'hEFCD_AB89;
  localparam word_t H_INIT_2 = 32'h98BA_DCFE;
  localparam word_t H_INIT_3 = 32'h1032_5476;
  localparam word_t H_INIT_4 = 32'hC3D2_E1F0;

  localparam round_t    ROUND_F1   = 7'd20;
  localparam round_t    ROUND_F2   = 7'd40;
  localparam round_t    ROUND_F3   = 7'd60;
  localparam round_t    ROUND_LAST = 7'd79;

  localparam byte_pos_t POS_LEN    = 6'd56;   // bit position 448
  localparam byte_pos_t POS_LAST   = 6'd63;   // bit position 504
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam word_idx_t LAST_WORD  = 3'd4;

endpackage

// ===== rtl/sha1_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_sched
// Sixteen-word block buffer. Takes message bytes big-endian, then acts as the
// message schedule window during compression: word 0 is the current W(t).
// ----------------------------------------------------------------------------
module sha1_sched
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      wr_en,
  input  byte_pos_t wr_pos,
  input  logic [7:0] wr_byte,
  input  logic      shift_en,
  output word_t     wt
);

  word_t words_r [16];
  word_t w_new;

  // W(t+16) = rotl1(W(t+13) ^ W(t+8) ^ W(t+2) ^ W(t))
  always_comb begin
    w_new = words_r[13] ^ words_r[8] ^ words_r[2] ^ words_r[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  assign wt = words_r[0];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        words_r[i] <= words_r[i+1];
      end
      words_r[15] <= w_new;
    end else if (wr_en) begin
      words_r[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

endmodule

// ===== rtl/sha1_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_round
// One SHA-1 round: selects f and K by round number and updates a..e.
// ----------------------------------------------------------------------------
module sha1_round
  import sha1_pkg::*;
(
  input  abcde_t cur,
  input  round_t round,
  input  word_t  wt,
  output abcde_t nxt
);

  word_t f;
  word_t k;

  always_comb begin
    if (round < ROUND_F1) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K_0;
    end else if (round < ROUND_F2) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_1;
    end else if (round < ROUND_F3) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K_2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_3;
    end
  end

  always_comb begin
    nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + wt;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// ===== rtl/sha1_message_digest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 engine, one message byte per input item, five digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_action = 0 absorbs in_data_byte,
//   in_action = 1 ends the message. Output channel (out_valid/out_ready):
//   five items, out_word_index 0..4, out_last set on the fifth.
// Timing:
//   Absorb items are taken back to back while the engine is idle. The byte
//   that fills a 64-byte block starts a compression: the rounds on the shared
//   round unit, then one fold step; in_ready is low until the fold is done.
//   A finish item writes padding at one byte per cycle (9 to 72 bytes), runs
//   one or two compressions, then presents the digest words one per cycle
//   while out_ready is high. The round loop sets the throughput.
// Reset: chaining words load the SHA-1 initial values, the bit count clears,
//   the engine is idle and ready.
// Stall: while out_ready is low the current digest word holds; no new input
//   item is taken until the fifth word is delivered. Afterwards the engine
//   is back at its initial state for the next message.
// ----------------------------------------------------------------------------
module sha1_message_digest
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_word_index,
  output logic [31:0] out_digest_word,
  output logic        out_last
);

  state_t       state_r, state_nxt;
  word_t        chain_r [5];
  word_t        chain_nxt [5];
  abcde_t       abcde_r, abcde_nxt, abcde_rnd;
  round_t       round_r, round_nxt;
  logic [60:0]  byte_cnt_r, byte_cnt_nxt;
  logic [63:0]  len_r, len_nxt;
  logic         finishing_r, finishing_nxt;
  logic         pad_first_r, pad_first_nxt;
  logic         len_phase_r, len_phase_nxt;
  logic         pad_done_r, pad_done_nxt;
  word_idx_t    idx_r, idx_nxt;

  byte_pos_t    pos;
  logic         in_acc;
  logic         out_acc;
  logic         is_len;
  logic [7:0]   pad_byte;
  logic         wr_en;
  logic [7:0]   wr_byte;
  logic         shift_en;
  word_t        wt;

  assign pos     = byte_cnt_r[5:0];
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // length bytes start at position 56 once the marker byte is out
  assign is_len = !pad_first_r && (len_phase_r || (pos == POS_LEN));

  always_comb begin
    if (pad_first_r) begin
      pad_byte = PAD_MARK;
    end else if (is_len) begin
      pad_byte = len_r[{~pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  sha1_sched u_sched (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_pos   (pos),
    .wr_byte  (wr_byte),
    .shift_en (shift_en),
    .wt       (wt)
  );

  sha1_round u_round (
    .cur   (abcde_r),
    .round (round_r),
    .wt    (wt),
    .nxt   (abcde_rnd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_FINISH) begin
            state_nxt = ST_PAD;
          end else if (pos == POS_LAST) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (pos == POS_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!finishing_r) begin
          state_nxt = ST_IDLE;
        end else if (pad_done_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ready && idx_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    wr_en     = 1'b0;
    wr_byte   = pad_byte;
    shift_en  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        wr_en    = in_valid && (in_action == ACT_ABSORB);
        wr_byte  = in_data_byte;
      end
      ST_PAD:   wr_en     = 1'b1;
      ST_ROUND: shift_en  = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_word_index  = idx_r;
  assign out_digest_word = chain_r[idx_r];
  assign out_last        = (idx_r == LAST_WORD);

  // datapath next values
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    abcde_nxt     = abcde_r;
    round_nxt     = round_r;
    byte_cnt_nxt  = byte_cnt_r;
    len_nxt       = len_r;
    finishing_nxt = finishing_r;
    pad_first_nxt = pad_first_r;
    len_phase_nxt = len_phase_r;
    pad_done_nxt  = pad_done_r;
    idx_nxt       = idx_r;

    if (wr_en) begin
      byte_cnt_nxt = byte_cnt_r + 61'd1;
      if (pos == POS_LAST) begin
        abcde_nxt = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                      d: chain_r[3], e: chain_r[4]};
        round_nxt = '0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_action == ACT_FINISH) begin
          len_nxt       = {byte_cnt_r, 3'b000};
          finishing_nxt = 1'b1;
          pad_first_nxt = 1'b1;
          len_phase_nxt = 1'b0;
          pad_done_nxt  = 1'b0;
        end
      end
      ST_PAD: begin
        pad_first_nxt = 1'b0;
        if (is_len) begin
          len_phase_nxt = 1'b1;
          if (pos == POS_LAST) begin
            pad_done_nxt = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        abcde_nxt = abcde_rnd;
        round_nxt = round_r + 7'd1;
      end
      ST_FOLD: begin
        chain_nxt[0] = chain_r[0] + abcde_r.a;
        chain_nxt[1] = chain_r[1] + abcde_r.b;
        chain_nxt[2] = chain_r[2] + abcde_r.c;
        chain_nxt[3] = chain_r[3] + abcde_r.d;
        chain_nxt[4] = chain_r[4] + abcde_r.e;
        idx_nxt      = '0;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (idx_r == LAST_WORD) begin
            chain_nxt[0]  = H_INIT_0;
            chain_nxt[1]  = H_INIT_1;
            chain_nxt[2]  = H_INIT_2;
            chain_nxt[3]  = H_INIT_3;
            chain_nxt[4]  = H_INIT_4;
            byte_cnt_nxt  = '0;
            finishing_nxt = 1'b0;
            idx_nxt       = '0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r[0]  <= H_INIT_0;
      chain_r[1]  <= H_INIT_1;
      chain_r[2]  <= H_INIT_2;
      chain_r[3]  <= H_INIT_3;
      chain_r[4]  <= H_INIT_4;
      round_r     <= '0;
      byte_cnt_r  <= '0;
      finishing_r <= 1'b0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
      pad_done_r  <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
      round_r     <= round_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      finishing_r <= finishing_nxt;
      pad_first_r <= pad_first_nxt;
      len_phase_r <= len_phase_nxt;
      pad_done_r  <= pad_done_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    abcde_r <= abcde_nxt;
    len_r   <= len_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while digest pending");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r <= ROUND_LAST))
    else $error("round counter out of range");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (in_ready && byte_cnt_r == '0))
    else $error("engine not restarted after digest");

  a_out_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (pad_done_r && out_word_index == '0))
    else $error("digest output before padding done");

endmodule

// ===== verif/sha1_message_digest_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest_test
// Self-checking bench for the byte-stream SHA-1 engine. Messages go in one
// byte per item and end with a finish item. A behavioral SHA-1 in the
// scoreboard forms the five digest words for each finish, and every word
// that comes out is compared field by field, in order. Both channels idle in
// random bursts. The receiver holds off once for a long stretch so that the
// input stalls, and the sender drains the engine once in mid-run.
// ----------------------------------------------------------------------------
module sha1_message_digest_test;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 400;
  localparam int TARGET_ITEMS = 300;
  localparam int QUIET_ITEMS  = 260;
  localparam int MIN_FINISHES = 12;
  localparam int TAIL_CYCLES  = 200;

  class sha1_digest_board;
    typedef struct {
      word_idx_t idx;
      word_t     word;
      logic      last;
    } digest_word_t;

    word_t        chain[5];
    word_t        blk[16];
    logic [63:0]  bit_count;
    digest_word_t digest_q[$];
    int           errors;

    function new();
      errors = 0;
      foreach (blk[i]) blk[i] = '0;
      restart();
    endfunction

    function void restart();
      chain[0]  = H_INIT_0;
      chain[1]  = H_INIT_1;
      chain[2]  = H_INIT_2;
      chain[3]  = H_INIT_3;
      chain[4]  = H_INIT_4;
      bit_count = '0;
    endfunction

    function word_t rotl(word_t v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void fold_block();
      word_t w[16];
      word_t a, b, c, d, e, f, k, wt, sum;
      w = blk;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          wt = w[t];
        end else begin
          wt = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
          w[t % 16] = wt;
        end
        if (t < ROUND_F1) begin
          f = (b & c) | (~b & d);
          k = K_0;
        end else if (t < ROUND_F2) begin
          f = b ^ c ^ d;
          k = K_1;
        end else if (t < ROUND_F3) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_2;
        end else begin
          f = b ^ c ^ d;
          k = K_3;
        end
        sum = rotl(a, 5) + f + e + k + wt;
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // bytes land big-endian within each 32-bit block word
    function void absorb(logic [7:0] data);
      byte_pos_t pos;
      int        lane;
      pos  = bit_count[8:3];
      lane = 3 - int'(pos[1:0]);
      blk[pos[5:2]][lane*8 +: 8] = data;
      bit_count = bit_count + 64'd8;
      if (pos == POS_LAST) fold_block();
    endfunction

    function void finish_message();
      logic [63:0]  msg_bits;
      digest_word_t dw;
      msg_bits = bit_count;
      absorb(PAD_MARK);
      while (bit_count[8:3] != POS_LEN) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(msg_bits[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        dw.idx  = word_idx_t'(i);
        dw.word = chain[i];
        dw.last = (dw.idx == LAST_WORD);
        digest_q.push_back(dw);
      end
      restart();
    endfunction

    function void note_input(logic act, logic [7:0] data);
      if (act == ACT_FINISH) finish_message();
      else absorb(data);
    endfunction

    function int words_due();
      return digest_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(word_idx_t idx, word_t word, logic last);
      digest_word_t want;
      if (digest_q.size() == 0) begin
        report($sformatf("digest word %0d = %h with none pending", idx, word));
        return;
      end
      want = digest_q.pop_front();
      if (idx !== want.idx)
        report($sformatf("word_index %0d, want %0d", idx, want.idx));
      if (word !== want.word)
        report($sformatf("digest word %0d = %h, want %h", want.idx, word, want.word));
      if (last !== want.last)
        report($sformatf("last %b on word %0d, want %b", last, want.idx, want.last));
    endtask
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_action    = ACT_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  out_word_index;
  logic [31:0] out_digest_word;
  logic        out_last;

  sha1_digest_board sb;
  int  items_sent    = 0;
  int  finishes_sent = 0;
  int  cycle_count   = 0;
  bit  quiet_tail    = 1'b0;
  bit  hold_req      = 1'b0;
  bit  hold_done     = 1'b0;

  sha1_message_digest DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word_index  (out_word_index),
    .out_digest_word (out_digest_word),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sha1_message_digest_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_word_index, out_digest_word, out_last);
  end

  // result side: random stalls, one long hold-off on request, none at the tail
  initial begin : digest_sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] data, input bit calm);
    if (!calm && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(act, data);
    items_sent++;
    if (act == ACT_FINISH) finishes_sent++;
    if (items_sent >= QUIET_ITEMS) quiet_tail = 1'b1;
  endtask

  task automatic send_message(input int len, input bit calm);
    for (int i = 0; i < len; i++) send_item(ACT_ABSORB, 8'($urandom), calm);
    send_item(ACT_FINISH, 8'($urandom), calm);
  endtask

  // mostly short messages; now and then a length on a padding or block edge
  task automatic send_random_message();
    int boundary_lens[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int len;
    if ($urandom_range(0, 5) == 0) len = boundary_lens[$urandom_range(0, 9)];
    else len = $urandom_range(0, 12);
    send_message(len, $urandom_range(0, 3) == 0);
  endtask

  initial begin : stimulus
    int msg_count;
    sb = new();
    msg_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, "abc", byte extremes, ignored byte on finish
    send_item(ACT_FINISH, 8'h00, 1'b0);
    send_item(ACT_ABSORB, 8'h61, 1'b0);
    send_item(ACT_ABSORB, 8'h62, 1'b0);
    send_item(ACT_ABSORB, 8'h63, 1'b0);
    send_item(ACT_FINISH, 8'h00, 1'b0);
    send_item(ACT_ABSORB, 8'h00, 1'b0);
    send_item(ACT_ABSORB, 8'hFF, 1'b0);
    send_item(ACT_FINISH, 8'hFF, 1'b0);
    send_item(ACT_FINISH, 8'hA5, 1'b1);
    send_item(ACT_ABSORB, PAD_MARK, 1'b1);
    send_item(ACT_FINISH, 8'h5A, 1'b1);

    while (items_sent < TARGET_ITEMS || finishes_sent < MIN_FINISHES) begin
      if (msg_count == 1) begin
        // receiver goes quiet; a short message then fills the output and blocks input
        in_valid <= 1'b0;
        hold_req = 1'b1;
        wait (hold_done);
        @(posedge clk);
        send_message(4, 1'b1);
        send_message(3, 1'b1);
      end else if (msg_count == 2) begin
        send_random_message();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.words_due() != 0) @(posedge clk);
      end else begin
        send_random_message();
      end
      msg_count++;
    end

    in_valid <= 1'b0;
    while (sb.words_due() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sha1_message_digest_test: clean");
    end else begin
      $display("sha1_message_digest_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sha1_pkg.sv
rtl/sha1_sched.sv
rtl/sha1_round.sv
rtl/sha1_message_digest.sv
verif/sha1_message_digest_test.sv
